@@ rtl/mss_pkg.sv @@
// mss_pkg: shared constants and types for the merge sort sequence block.
// No dependencies; imported by every module under rtl/.
package mss_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int VALUE_W       = 32;
  localparam int Q_DEPTH       = 4;
  localparam int Q_AW          = 2;

  // One classified input item as it travels from front to back.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
    logic                      drop;
  } mss_entry_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETUP,
    ST_MERGE,
    ST_EMIT
  } mss_state_t;

endpackage

@@ rtl/mss_front.sv @@
// mss_front: input side; counts the items of a sequence and marks overflow.
// Depends on mss_pkg.
module mss_front #(
  parameter int MAX_ITEMS = mss_pkg::MAX_ITEMS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [mss_pkg::VALUE_W-1:0]    in_item_value,
  input  logic                                  in_item_last,
  output logic                                  push_valid,
  input  logic                                  push_ready,
  output mss_pkg::mss_entry_t                   push_entry
);
  import mss_pkg::*;

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);

  logic [CW-1:0] count_r, count_nxt;
  logic          full;

  assign full     = (count_r == MAX_C);
  assign in_ready = push_ready;

  always_comb begin
    push_valid       = in_valid;
    push_entry.value = in_item_value;
    push_entry.last  = in_item_last;
    push_entry.drop  = full;
    count_nxt        = count_r;
    if (in_valid && push_ready) begin
      if (in_item_last) begin
        count_nxt = '0;
      end else if (!full) begin
        count_nxt = count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

@@ rtl/mss_queue.sv @@
// mss_queue: small FIFO of classified items between front and back.
// Depends on mss_pkg.
module mss_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  mss_pkg::mss_entry_t push_entry,
  output logic                pop_valid,
  input  logic                pop_ready,
  output mss_pkg::mss_entry_t pop_entry
);
  import mss_pkg::*;

  mss_entry_t        slot_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]     cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != (Q_AW+1)'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_entry  = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ rtl/mss_back.sv @@
// mss_back: loads items into a ping-pong buffer pair, merge sorts them
// bottom-up across the pair and streams them out. Depends on mss_pkg.
module mss_back #(
  parameter int MAX_ITEMS = mss_pkg::MAX_ITEMS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_valid,
  output logic                                  q_ready,
  input  mss_pkg::mss_entry_t                   q_entry,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [mss_pkg::VALUE_W-1:0]    out_sorted_value,
  output logic                                  out_sorted_last,
  output logic                                  out_overflow_flag
);
  import mss_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int SW = CW + 2;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);

  function automatic logic [CW-1:0] clip(input logic [SW-1:0] v, input logic [CW-1:0] lim);
    logic [SW-1:0] lim_x;
    lim_x = SW'(lim);
    return (v > lim_x) ? lim : v[CW-1:0];
  endfunction

  // two banks, one write port and two registered read ports each
  logic signed [VALUE_W-1:0] bank0 [MAX_ITEMS];
  logic signed [VALUE_W-1:0] bank1 [MAX_ITEMS];
  logic signed [VALUE_W-1:0] rd0a, rd0b, rd1a, rd1b;

  mss_state_t    state_r, state_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic          dropped_r, dropped_nxt;
  logic          src_r, src_nxt;
  logic [SW-1:0] width_r, width_nxt;
  logic [CW-1:0] lo_r, lo_nxt, mid_r, mid_nxt, hi_r, hi_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [CW-1:0] e_r, e_nxt;
  logic          pf_r, pf_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_ovf_r, out_ovf_nxt;
  logic          out_load;

  logic [CW-1:0] addr_a, addr_b, wr_addr, n_new;
  logic signed [VALUE_W-1:0] wr_data, src_a, src_b;
  logic          wr0_en, wr1_en;
  logic          a_ok, b_ok, take_a, out_free;
  logic [SW-1:0] w2, hi_x;

  assign src_a    = src_r ? rd1a : rd0a;
  assign src_b    = src_r ? rd1b : rd0b;
  assign a_ok     = (i_r < mid_r);
  assign b_ok     = (j_r < hi_r);
  assign take_a   = a_ok && (!b_ok || (src_a < src_b));
  assign out_free = !out_valid_r || out_ready;
  assign w2       = width_r << 1;
  assign hi_x     = SW'(hi_r);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    dropped_nxt   = dropped_r;
    src_nxt       = src_r;
    width_nxt     = width_r;
    lo_nxt        = lo_r;
    mid_nxt       = mid_r;
    hi_nxt        = hi_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    e_nxt         = e_r;
    pf_nxt        = pf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    out_load      = 1'b0;
    q_ready       = 1'b0;
    wr0_en        = 1'b0;
    wr1_en        = 1'b0;
    wr_addr       = n_r;
    wr_data       = q_entry.value;
    addr_a        = '0;
    addr_b        = '0;
    n_new         = n_r;

    unique case (state_r)
      ST_LOAD: begin
        q_ready = 1'b1;
        if (q_valid) begin
          if (q_entry.drop) begin
            dropped_nxt = 1'b1;
          end else begin
            wr0_en = 1'b1;
            n_new  = n_r + CW'(1);
          end
          n_nxt = n_new;
          if (q_entry.last) begin
            width_nxt = SW'(1);
            src_nxt   = 1'b0;
            lo_nxt    = '0;
            mid_nxt   = clip(SW'(1), n_new);
            hi_nxt    = clip(SW'(2), n_new);
            e_nxt     = '0;
            pf_nxt    = 1'b0;
            state_nxt = (n_new > CW'(1)) ? ST_SETUP : ST_EMIT;
          end
        end
      end

      ST_SETUP: begin
        addr_a    = lo_r;
        addr_b    = mid_r;
        i_nxt     = lo_r;
        j_nxt     = mid_r;
        k_nxt     = lo_r;
        state_nxt = ST_MERGE;
      end

      ST_MERGE: begin
        wr_data = take_a ? src_a : src_b;
        wr_addr = k_r;
        wr0_en  = src_r;
        wr1_en  = !src_r;
        i_nxt   = i_r + CW'(take_a);
        j_nxt   = j_r + CW'(!take_a);
        k_nxt   = k_r + CW'(1);
        addr_a  = i_nxt;
        addr_b  = j_nxt;
        if (k_nxt == hi_r) begin
          if (hi_r == n_r) begin
            // pass done: swap banks, double the run width
            src_nxt   = !src_r;
            width_nxt = w2;
            if (w2 >= SW'(n_r)) begin
              e_nxt     = '0;
              pf_nxt    = 1'b0;
              state_nxt = ST_EMIT;
            end else begin
              lo_nxt    = '0;
              mid_nxt   = clip(w2, n_r);
              hi_nxt    = clip(w2 << 1, n_r);
              state_nxt = ST_SETUP;
            end
          end else begin
            lo_nxt    = hi_r;
            mid_nxt   = clip(hi_x + width_r, n_r);
            hi_nxt    = clip(hi_x + w2, n_r);
            state_nxt = ST_SETUP;
          end
        end
      end

      ST_EMIT: begin
        addr_a = e_r;
        pf_nxt = 1'b1;
        if (pf_r && out_free) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          out_value_nxt = src_a;
          out_last_nxt  = (e_r + CW'(1) == n_r);
          out_ovf_nxt   = dropped_r;
          e_nxt         = e_r + CW'(1);
          addr_a        = e_nxt;
          if (out_last_nxt) begin
            n_nxt       = '0;
            dropped_nxt = 1'b0;
            state_nxt   = ST_LOAD;
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      n_r         <= '0;
      dropped_r   <= 1'b0;
      pf_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      dropped_r   <= dropped_nxt;
      pf_r        <= pf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r       <= src_nxt;
    width_r     <= width_nxt;
    lo_r        <= lo_nxt;
    mid_r       <= mid_nxt;
    hi_r        <= hi_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    e_r         <= e_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr0_en) begin
      bank0[wr_addr[AW-1:0]] <= wr_data;
    end
    rd0a <= bank0[addr_a[AW-1:0]];
    rd0b <= bank0[addr_b[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr1_en) begin
      bank1[wr_addr[AW-1:0]] <= wr_data;
    end
    rd1a <= bank1[addr_a[AW-1:0]];
    rd1b <= bank1[addr_b[AW-1:0]];
  end

  assign out_valid         = out_valid_r;
  assign out_sorted_value  = out_value_r;
  assign out_sorted_last   = out_last_r;
  assign out_overflow_flag = out_ovf_r;

  a_merge_has_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MERGE) |-> (a_ok || b_ok))
    else $error("merge step with both runs exhausted");

  a_merge_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MERGE) |-> (k_r < hi_r))
    else $error("merge write beyond run end");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= MAX_C)
    else $error("stored count beyond capacity");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (e_r < n_r))
    else $error("emit index beyond stored count");

endmodule

@@ rtl/merge_sort_sequence.sv @@
// merge_sort_sequence: top level of the sequence sorter.
// Depends on mss_pkg, mss_front, mss_queue, mss_back.
//
//  channel | ports                                          | transfer when
//  --------+------------------------------------------------+---------------------
//  input   | in_valid, in_ready, in_item_value, in_item_last | in_valid & in_ready
//  result  | out_valid, out_ready, out_sorted_value,         | out_valid & out_ready
//          | out_sorted_last, out_overflow_flag              |
//
// Sequence: loading takes one item per cycle as the queue supplies them. On the
//   last item the back end runs ceil(log2 n) merge passes over two ping-pong
//   buffers, each pass with a setup step per run, then streams n results at one
//   per cycle while out_ready is high.
// The merge compare (one 32-bit signed compare on registered read data) and the
//   single write port of each buffer set the rate of a pass.
// Reset (rst_n, synchronous) empties the queue and clears counts and valids;
//   buffer contents are not cleared, entries are only read after being written.
// The front keeps taking items into a four-entry queue while the back sorts or
//   waits on out_ready; once four transfers wait there, in_ready drops until the
//   back end is loading again.
module merge_sort_sequence #(
  parameter int MAX_ITEMS = mss_pkg::MAX_ITEMS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [mss_pkg::VALUE_W-1:0] in_item_value,
  input  logic                               in_item_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [mss_pkg::VALUE_W-1:0] out_sorted_value,
  output logic                               out_sorted_last,
  output logic                               out_overflow_flag
);
  import mss_pkg::*;

  // front -> queue
  logic       push_valid, push_ready;
  mss_entry_t push_entry;
  // queue -> back
  logic       pop_valid, pop_ready;
  mss_entry_t pop_entry;

  // Front: tracks the sequence length and tags items that do not fit.
  mss_front #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_item_value (in_item_value),
    .in_item_last  (in_item_last),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_entry    (push_entry)
  );

  // Decoupling queue: lets input transfers continue while the back end is busy.
  mss_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // Back: buffer load, bottom-up merge passes, result streaming.
  mss_back #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (pop_valid),
    .q_ready           (pop_ready),
    .q_entry           (pop_entry),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sorted_value  (out_sorted_value),
    .out_sorted_last   (out_sorted_last),
    .out_overflow_flag (out_overflow_flag)
  );

endmodule
